### rtl/hierarchical_bitmap_slot_allocator_defines.svh
// Assertion macros for the hierarchical bitmap slot allocator.
`ifndef HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond holds in this cycle implies prop in the same cycle
`define HBSA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("hbsa: same-cycle check failed");

// cond holds in this cycle implies prop in the next cycle
`define HBSA_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("hbsa: next-cycle check failed");

// prop holds in the cycle after reset is applied
`define HBSA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> (prop)) \
    else $error("hbsa: reset check failed");

`else

`define HBSA_ASSERT_IMP(lbl, cond, prop)
`define HBSA_ASSERT_NXT(lbl, cond, prop)
`define HBSA_ASSERT_RST(lbl, prop)

`endif

`endif

### rtl/hbsa_pkg.sv
// Types, codes and helpers shared by the slot allocator modules.
package hbsa_pkg;

  localparam int WORD_BITS = 64;
  localparam int WADDR_W   = 8;
  localparam int BIT_W     = 14;
  localparam int SLOT_W    = 13;
  localparam int IDX_W     = 12;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // reciprocal of 63 for small dividends, scaled by 2**20
  localparam logic [14:0] RECIP_63   = 15'd16645;
  localparam logic [6:0]  SLOT_ROUND = 7'd61;

  // cumulative sizes of the first tree levels, in bits
  localparam logic [BIT_W-1:0] LVL1_BITS = 14'd64;
  localparam logic [BIT_W-1:0] LVL2_BITS = 14'd4160;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_slot;
    logic [1:0]       status;
    logic             all_full;
  } out_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slots;
    logic [BIT_W-1:0]     heap_bits;
    logic [WADDR_W-1:0]   heap_words;
    logic [BIT_W-1:0]     last_level;
    logic [BIT_W-1:0]     base_lo;
    logic [BIT_W-1:0]     base_hi;
    logic [WORD_BITS-1:0] pad_word;
  } geom_t;

  typedef struct packed {
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clear;
  } store_req_t;

  function automatic logic [6:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [6:0] r;
    r = 7'd64;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) r = 7'(i);
    end
    return r;
  endfunction

endpackage

### rtl/hierarchical_bitmap_slot_allocator.sv
// Top level of the hierarchical bitmap slot allocator.
//
// A command word (action, slot_index) is taken when start is high and busy
// is low. Allocate returns the lowest free slot, free releases slot_index,
// clear empties the tree. Each command yields one result word on out_word,
// marked by a single-cycle out_strobe; the receiver cannot hold it off.
// Clear, an unused action, a bad free index and allocate when full are
// answered from the idle state without a tree walk. Allocate reads one tree
// word per level on the way down, checks the slot, writes the leaf and
// checks parent words on the way up. Free maps the slot, does a leaf
// read-modify-write and checks parent words on the way up. The registered
// tree memory needs one read-modify-write per level; busy stays high while
// a command runs. The next command is taken once busy falls.
// A write on cfg_we sets the slot count, empties the tree and keeps busy
// high while the geometry is rebuilt in the G_MUL, G_SUM and G_FIN states.
// Reset does the same with 4096 slots (or MAX_SLOTS if smaller).
`include "hierarchical_bitmap_slot_allocator_defines.svh"

module hierarchical_bitmap_slot_allocator import hbsa_pkg::*; #(
  parameter int MAX_SLOTS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              out_strobe,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata
);

  localparam int EFF_SLOTS = (MAX_SLOTS < 8191) ? MAX_SLOTS : 8191;
  localparam int MAX_BITS  = EFF_SLOTS + (EFF_SLOTS + WORD_BITS - 3) / (WORD_BITS - 1);
  localparam int MAX_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;

  geom_t                geo;
  logic                 geo_busy;
  store_req_t           req;
  logic [WORD_BITS-1:0] rd_data;

  hbsa_geom #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .geo      (geo),
    .busy     (geo_busy)
  );

  hbsa_store #(
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .last_addr(geo.heap_words - WADDR_W'(1)),
    .pad_word (geo.pad_word),
    .rd_data  (rd_data)
  );

  hbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .geo       (geo),
    .geo_busy  (geo_busy),
    .rd_data   (rd_data),
    .req       (req),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  `HBSA_ASSERT_RST(a_no_strobe_after_rst, !out_strobe)
  `HBSA_ASSERT_NXT(a_accept_progress, start && !busy, busy || out_strobe)
  `HBSA_ASSERT_IMP(a_strobe_has_cause, out_strobe, $past(busy) || $past(start))

endmodule

### rtl/hbsa_store.sv
// Tree word memory with per-word valid bits and reset-value substitution.
module hbsa_store import hbsa_pkg::*; #(
  parameter int DEPTH = 65
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  store_req_t           req,
  input  logic [WADDR_W-1:0]   last_addr,
  input  logic [WORD_BITS-1:0] pad_word,
  output logic [WORD_BITS-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid_r;
  logic [WORD_BITS-1:0] q_r;
  logic                 rd_valid_r;
  logic [WADDR_W-1:0]   rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    q_r       <= mem[req.rd_addr[AW-1:0]];
    rd_addr_r <= req.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[req.rd_addr[AW-1:0]];
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid_r ? q_r :
                   ((rd_addr_r == last_addr) ? pad_word : '0);

endmodule

### rtl/hbsa_geom.sv
// Heap geometry calculator, run after reset and on each slot count write.
module hbsa_geom import hbsa_pkg::*; #(
  parameter int MAX_SLOTS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata,
  output geom_t             geo,
  output logic              busy
);

  localparam int EFF_SLOTS = (MAX_SLOTS < 8191) ? MAX_SLOTS : 8191;
  localparam int RST_SLOTS = (EFF_SLOTS < 4096) ? EFF_SLOTS : 4096;
  localparam logic [SLOT_W-1:0] EFF_N = SLOT_W'(EFF_SLOTS);
  localparam logic [SLOT_W-1:0] RST_N = SLOT_W'(RST_SLOTS);

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_MUL  = 2'd1;
  localparam logic [1:0] G_SUM  = 2'd2;
  localparam logic [1:0] G_FIN  = 2'd3;

  logic [1:0]        state_r;
  logic [SLOT_W-1:0] n_r;
  logic [7:0]        q_r;
  logic [BIT_W-1:0]  hb_r;
  geom_t             geo_r;

  logic [SLOT_W-1:0] n_in;
  logic [BIT_W-1:0]  mul_x;
  logic [28:0]       prod;
  logic [BIT_W-1:0]  hb_nxt;
  logic [BIT_W-1:0]  hw_sum;
  logic [BIT_W-1:0]  ll;
  logic [BIT_W-1:0]  base_lo;
  logic [5:0]        rem;

  assign n_in = (cfg_wdata == '0) ? SLOT_W'(1) :
                ((cfg_wdata > EFF_N) ? EFF_N : cfg_wdata);

  assign mul_x  = BIT_W'(n_r) + BIT_W'(SLOT_ROUND);
  assign prod   = 29'(mul_x) * 29'(RECIP_63);
  assign hb_nxt = (q_r == '0) ? BIT_W'(n_r) : (BIT_W'(n_r) + BIT_W'(q_r) - BIT_W'(1));

  assign hw_sum  = hb_r + BIT_W'(WORD_BITS - 1);
  assign base_lo = (hb_r <= LVL1_BITS) ? '0 :
                   ((hb_r <= LVL2_BITS) ? LVL1_BITS : LVL2_BITS);
  assign ll      = hb_r - base_lo;
  assign rem     = hb_r[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_MUL;
      n_r     <= RST_N;
    end else if (cfg_we) begin
      state_r <= G_MUL;
      n_r     <= n_in;
    end else begin
      unique case (state_r)
        G_MUL: begin
          q_r     <= prod[27:20];
          state_r <= G_SUM;
        end
        G_SUM: begin
          hb_r    <= hb_nxt;
          state_r <= G_FIN;
        end
        G_FIN: begin
          geo_r.slots      <= n_r;
          geo_r.heap_bits  <= hb_r;
          geo_r.heap_words <= hw_sum[13:6];
          geo_r.last_level <= ll;
          geo_r.base_lo    <= base_lo;
          geo_r.base_hi    <= {6'b0, hw_sum[13:6]} - BIT_W'(1) - ll;
          geo_r.pad_word   <= (rem == '0) ? '0 :
                              ~((64'd1 << rem) - 64'd1);
          state_r          <= G_IDLE;
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign geo  = geo_r;
  assign busy = (state_r != G_IDLE);

endmodule

### rtl/hbsa_ctrl.sv
// Sequencer for descent, leaf update and upward propagation over the store.
module hbsa_ctrl import hbsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_word_t             in_word,
  input  logic                 cfg_we,
  input  geom_t                geo,
  input  logic                 geo_busy,
  input  logic [WORD_BITS-1:0] rd_data,
  output store_req_t           req,
  output logic                 busy,
  output logic                 out_strobe,
  output out_word_t            out_word
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_EV  = 4'd2;
  localparam logic [3:0] S_A_MAP = 4'd3;
  localparam logic [3:0] S_A_CHK = 4'd4;
  localparam logic [3:0] S_F_MAP = 4'd5;
  localparam logic [3:0] S_F_CHK = 4'd6;
  localparam logic [3:0] S_L_RD  = 4'd7;
  localparam logic [3:0] S_L_WR  = 4'd8;
  localparam logic [3:0] S_U_RD  = 4'd9;
  localparam logic [3:0] S_U_WR  = 4'd10;

  logic [3:0]           state_r;
  logic                 set_r;
  logic [WADDR_W-1:0]   w_r;
  logic [WADDR_W-1:0]   node_r;
  logic [BIT_W-1:0]     g_r;
  logic [BIT_W-1:0]     s_r;
  logic [WORD_BITS-1:0] cur_r;
  logic [IDX_W-1:0]     slot_r;
  logic [1:0]           status_r;
  logic                 strobe_r;
  logic                 root_full_r;

  logic                 accept;
  logic                 clr;
  logic [BIT_W-1:0]     hw_ext;
  logic [6:0]           ev_lc;
  logic [BIT_W-1:0]     ev_base;
  logic [BIT_W-1:0]     ev_nxt;
  logic [BIT_W-1:0]     ev_g;
  logic                 ev_down;
  logic                 ev_bad;
  logic [BIT_W-1:0]     map_s;
  logic [BIT_W-1:0]     idx_ext;
  logic [BIT_W-1:0]     fmap_g;
  logic [WORD_BITS-1:0] lw_word;
  logic [WORD_BITS-1:0] lw_mask;
  logic [WORD_BITS-1:0] lw_new;
  logic [WADDR_W-1:0]   nm1;
  logic [WADDR_W-1:0]   up;
  logic [WORD_BITS-1:0] u_mask;
  logic                 u_full;
  logic                 u_pbit;
  logic [WORD_BITS-1:0] u_new;

  assign busy   = (state_r != S_IDLE) || geo_busy;
  assign accept = start && !busy;
  assign clr    = cfg_we || (accept && (in_word.action == ACT_CLEAR));
  assign hw_ext = {6'b0, geo.heap_words};

  // descent step: lowest clear bit of the word just read
  assign ev_lc   = lowest_clear(rd_data);
  assign ev_base = {w_r, 6'b0};
  assign ev_nxt  = ev_base + BIT_W'(1) + BIT_W'(ev_lc);
  assign ev_g    = ev_base + BIT_W'(ev_lc);
  assign ev_down = ((ev_base + BIT_W'(1)) < hw_ext) && (ev_nxt < hw_ext);
  assign ev_bad  = ev_lc[6] || (ev_g >= geo.heap_bits) || ((ev_g + BIT_W'(1)) < hw_ext);

  // heap bit to slot and back
  assign map_s   = (g_r >= geo.base_lo) ? (g_r - geo.base_lo) : (g_r - geo.base_hi);
  assign idx_ext = BIT_W'(slot_r);
  assign fmap_g  = (idx_ext < geo.last_level) ? (geo.base_lo + idx_ext) :
                                                (geo.base_hi + idx_ext);

  assign lw_word = set_r ? cur_r : rd_data;
  assign lw_mask = 64'd1 << g_r[5:0];
  assign lw_new  = set_r ? (lw_word | lw_mask) : (lw_word & ~lw_mask);

  assign nm1    = node_r - WADDR_W'(1);
  assign up     = WADDR_W'(nm1 >> 6);
  assign u_mask = 64'd1 << nm1[5:0];
  assign u_full = &cur_r;
  assign u_pbit = rd_data[nm1[5:0]];
  assign u_new  = u_full ? (rd_data | u_mask) : (rd_data & ~u_mask);

  always_comb begin
    req.rd_addr = w_r;
    req.wr_en   = 1'b0;
    req.wr_addr = node_r;
    req.wr_data = lw_new;
    req.clear   = clr;
    unique case (state_r)
      S_L_RD: req.rd_addr = node_r;
      S_U_RD: req.rd_addr = up;
      S_L_WR: req.wr_en   = 1'b1;
      S_U_WR: begin
        req.wr_en   = (u_full != u_pbit);
        req.wr_addr = up;
        req.wr_data = u_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      strobe_r    <= 1'b0;
      root_full_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (clr) begin
        root_full_r <= 1'b0;
      end else if (req.wr_en && (req.wr_addr == '0)) begin
        root_full_r <= &req.wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            set_r    <= (in_word.action == ACT_ALLOC);
            status_r <= ST_OK;
            slot_r   <= '0;
            case (in_word.action)
              ACT_ALLOC: begin
                if (root_full_r) begin
                  status_r <= ST_FULL;
                  strobe_r <= 1'b1;
                end else begin
                  w_r     <= '0;
                  state_r <= S_A_RD;
                end
              end
              ACT_FREE: begin
                slot_r <= in_word.slot_index;
                if ({1'b0, in_word.slot_index} >= geo.slots) begin
                  status_r <= ST_BAD;
                  strobe_r <= 1'b1;
                end else begin
                  state_r <= S_F_MAP;
                end
              end
              default: strobe_r <= 1'b1;
            endcase
          end
        end
        S_A_RD: state_r <= S_A_EV;
        S_A_EV: begin
          if (ev_down) begin
            w_r     <= ev_nxt[WADDR_W-1:0];
            state_r <= S_A_RD;
          end else if (ev_bad) begin
            status_r <= ST_FULL;
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            g_r     <= ev_g;
            cur_r   <= rd_data;
            state_r <= S_A_MAP;
          end
        end
        S_A_MAP: begin
          s_r     <= map_s;
          state_r <= S_A_CHK;
        end
        S_A_CHK: begin
          if (s_r >= {1'b0, geo.slots}) begin
            status_r <= ST_FULL;
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            slot_r  <= s_r[IDX_W-1:0];
            node_r  <= g_r[13:6];
            state_r <= S_L_WR;
          end
        end
        S_F_MAP: begin
          g_r     <= fmap_g;
          state_r <= S_F_CHK;
        end
        S_F_CHK: begin
          if (g_r[13:6] >= geo.heap_words) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            node_r  <= g_r[13:6];
            state_r <= S_L_RD;
          end
        end
        S_L_RD: state_r <= S_L_WR;
        S_L_WR: begin
          cur_r <= lw_new;
          if (node_r == '0) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_U_RD;
          end
        end
        S_U_RD: state_r <= S_U_WR;
        S_U_WR: begin
          if ((u_full == u_pbit) || (up == '0)) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            cur_r   <= u_new;
            node_r  <= up;
            state_r <= S_U_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe            = strobe_r;
  assign out_word.granted_slot = slot_r;
  assign out_word.status       = status_r;
  assign out_word.all_full     = root_full_r;

endmodule
